// ===== rtl/core/owrse_pkg.sv =====
// Shared types and constants of the one-wire search ROM decision engine.
package owrse_pkg;

  localparam int unsigned ROM_BITS = 64;
  localparam int unsigned POS_W    = 7;
  localparam logic [7:0]  CRC_POLY = 8'h8C;
  localparam logic [7:0]  DEV_LIMIT_RESET = 8'd8;

  typedef enum logic [1:0] {
    OP_NEW_SEARCH = 2'd0,
    OP_START_PASS = 2'd1,
    OP_BIT_PAIR   = 2'd2
  } opcode_t;

  typedef enum logic [2:0] {
    ST_ACK     = 3'd0,
    ST_BIT     = 3'd1,
    ST_ABORT   = 3'd2,
    ST_VALID   = 3'd3,
    ST_CRCERR  = 3'd4,
    ST_IGNORED = 3'd5
  } status_t;

  typedef struct packed {
    logic [POS_W-1:0]    last_disc;
    logic [POS_W-1:0]    zero_pos;
    logic [POS_W-1:0]    bit_pos;
    logic [ROM_BITS-1:0] rom;
    logic [7:0]          crc;
    logic [7:0]          tally;
    logic                pass_active;
    logic                finished;
  } srch_state_t;

  typedef struct packed {
    logic                direction;
    logic                write_back;
    status_t             status;
    logic [ROM_BITS-1:0] rom_code;
    logic [7:0]          found_count;
    logic                search_finished;
  } srch_result_t;

endpackage

// ===== rtl/core/owrse_step.sv =====
// Combinational decision logic for one search word: next state and result.
module owrse_step import owrse_pkg::*; (
  input  srch_state_t  state_i,
  input  logic [1:0]   opcode_i,
  input  logic         id_bit_i,
  input  logic         complement_bit_i,
  input  logic [7:0]   dev_limit_i,
  output srch_state_t  state_o,
  output srch_result_t result_o
);

  logic [POS_W-1:0] pos_m1;
  logic [5:0]       idx;
  logic             dir;
  logic             mix;
  logic [7:0]       crc_n;
  logic [POS_W-1:0] lz_n;
  logic [7:0]       tally_n;
  status_t          status;
  logic             wb;

  assign pos_m1 = state_i.bit_pos - POS_W'(1);
  assign idx    = pos_m1[5:0];

  always_comb begin
    if (id_bit_i != complement_bit_i) begin
      dir = id_bit_i;
    end else if (state_i.bit_pos == state_i.last_disc) begin
      dir = 1'b1;
    end else if (state_i.bit_pos > state_i.last_disc) begin
      dir = 1'b0;
    end else begin
      dir = state_i.rom[idx];
    end
  end

  assign mix   = state_i.crc[0] ^ dir;
  assign crc_n = {1'b0, state_i.crc[7:1]} ^ (mix ? CRC_POLY : 8'h00);
  assign lz_n  = (id_bit_i == complement_bit_i && !dir) ? state_i.bit_pos : state_i.zero_pos;

  always_comb begin
    state_o = state_i;
    status  = ST_IGNORED;
    wb      = 1'b0;
    tally_n = state_i.tally;
    unique case (opcode_t'(opcode_i))
      OP_NEW_SEARCH: begin
        state_o.last_disc   = '0;
        state_o.rom         = '0;
        state_o.tally       = '0;
        state_o.finished    = 1'b0;
        state_o.pass_active = 1'b0;
        state_o.bit_pos     = POS_W'(1);
        status              = ST_ACK;
      end
      OP_START_PASS: begin
        if (!state_i.finished) begin
          state_o.bit_pos     = POS_W'(1);
          state_o.zero_pos    = '0;
          state_o.crc         = '0;
          state_o.pass_active = 1'b1;
          status              = ST_ACK;
        end
      end
      OP_BIT_PAIR: begin
        if (state_i.pass_active) begin
          if (id_bit_i && complement_bit_i) begin
            state_o.last_disc   = state_i.zero_pos;
            state_o.pass_active = 1'b0;
            state_o.finished    = (state_i.zero_pos == '0) ||
                                  (state_i.tally >= dev_limit_i);
            status              = ST_ABORT;
          end else begin
            state_o.rom[idx]  = dir;
            state_o.crc       = crc_n;
            state_o.zero_pos  = lz_n;
            wb                = 1'b1;
            status            = ST_BIT;
            if (state_i.bit_pos >= POS_W'(ROM_BITS)) begin
              if (crc_n == 8'h00) begin
                if (state_i.tally < dev_limit_i) begin
                  tally_n = state_i.tally + 8'd1;
                end
                status = ST_VALID;
              end else begin
                status = ST_CRCERR;
              end
              state_o.tally       = tally_n;
              state_o.bit_pos     = POS_W'(ROM_BITS + 1);
              state_o.last_disc   = lz_n;
              state_o.pass_active = 1'b0;
              state_o.finished    = (lz_n == '0) || (tally_n >= dev_limit_i);
            end else begin
              state_o.bit_pos = state_i.bit_pos + POS_W'(1);
            end
          end
        end
      end
      default: begin
        status = ST_IGNORED;
      end
    endcase
  end

  always_comb begin
    result_o.direction       = (status == ST_BIT || status == ST_VALID ||
                                status == ST_CRCERR) ? dir : 1'b0;
    result_o.write_back      = wb;
    result_o.status          = status;
    result_o.rom_code        = state_o.rom;
    result_o.found_count     = state_o.tally;
    result_o.search_finished = state_o.finished;
  end

endmodule

// ===== rtl/core/onewire_rom_search_engine_core.sv =====
// Top level of the one-wire search ROM decision engine.
// Throughput: one word per cycle while the output is not stalled by out_tready; each
// accepted word sits in an input register, the decision is combinational logic, and
// the answer waits in a result register.
// Reset (rst_n low, synchronous) clears the search state, empties both
// registers and sets the device limit to 8.
module onewire_rom_search_engine_core import owrse_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data,       // device limit
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,       // [0] id_bit, [1] complement_bit, [7:2] zero
  input  logic [1:0]  in_tuser,       // [1:0] opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,      // [0] direction, [1] write_back, [65:2] rom_code,
                                      // [73:66] found_count, [74] search_finished, [79:75] zero
  output logic [2:0]  out_tuser       // [2:0] status
);

  logic         in_valid_r;
  logic [1:0]   op_r;
  logic         id_bit_r;
  logic         cmp_bit_r;
  logic         out_valid_r;
  srch_result_t res_r;
  srch_result_t res_nxt;
  srch_state_t  state_r;
  srch_state_t  state_nxt;
  logic [7:0]   dev_limit_r;
  logic         advance;

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;
  assign cfg_ready = 1'b1;

  owrse_step u_step (
    .state_i          (state_r),
    .opcode_i         (op_r),
    .id_bit_i         (id_bit_r),
    .complement_bit_i (cmp_bit_r),
    .dev_limit_i      (dev_limit_r),
    .state_o          (state_nxt),
    .result_o         (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r            <= 1'b0;
      out_valid_r           <= 1'b0;
      dev_limit_r           <= DEV_LIMIT_RESET;
      state_r.last_disc     <= '0;
      state_r.zero_pos      <= '0;
      state_r.bit_pos       <= POS_W'(1);
      state_r.rom           <= '0;
      state_r.crc           <= '0;
      state_r.tally         <= '0;
      state_r.pass_active   <= 1'b0;
      state_r.finished      <= 1'b0;
    end else begin
      if (cfg_valid) begin
        dev_limit_r <= cfg_data;
      end
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (advance) begin
        state_r     <= state_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      op_r      <= in_tuser;
      id_bit_r  <= in_tdata[0];
      cmp_bit_r <= in_tdata[1];
    end
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, res_r.search_finished, res_r.found_count, res_r.rom_code,
                       res_r.write_back, res_r.direction};
  assign out_tuser  = res_r.status;

endmodule

// ===== verif/onewire_rom_search_engine_core_tb.sv =====
// Self-checking testbench for the one-wire search ROM decision engine, driven by simulated devices.
module onewire_rom_search_engine_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import owrse_pkg::*;

  localparam logic [1:0] OP_UNDEF    = 2'd3;
  localparam int         STALL_LIMIT = 2000;
  localparam int         PHASES      = 5;
  localparam int         PHASE_WORK  = 80;

  typedef struct packed {
    logic [1:0] op;
    logic       idb;
    logic       cmp;
  } bus_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data = 8'd0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'd0;
  logic [1:0]  in_tuser = 2'd0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [79:0] out_tdata;
  logic [2:0]  out_tuser;

  bus_word_t    outgoing_words[$];
  srch_result_t pending_results[$];
  logic [63:0]  bus_roms[$];
  srch_state_t  plan_state;
  srch_state_t  track_state;
  logic [7:0]   max_dev = DEV_LIMIT_RESET;
  int unsigned  send_idle = 0;
  int unsigned  recv_stall = 0;
  int           sent_cnt = 0;
  int           done_cnt = 0;
  int           work_cnt = 0;
  int           err_cnt = 0;
  int           quiet_cycles = 0;

  onewire_rom_search_engine_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [7:0] crc8_shift(input logic [7:0] crc, input logic b);
    logic [7:0] nxt;
    nxt = {1'b0, crc[7:1]};
    if (crc[0] ^ b) begin
      nxt = nxt ^ CRC_POLY;
    end
    return nxt;
  endfunction

  task automatic close_pass(inout srch_state_t s, input logic [7:0] limit);
    s.last_disc   = s.zero_pos;
    s.pass_active = 1'b0;
    s.finished    = (s.last_disc == '0) || (s.tally >= limit);
  endtask

  task automatic search_decide(inout srch_state_t s, input logic [7:0] limit,
                               input logic [1:0] op, input logic idb, input logic cmp,
                               output srch_result_t r);
    logic [5:0] idx;
    logic       d;
    r = '0;
    r.status = ST_IGNORED;
    d = 1'b0;
    if (op == OP_NEW_SEARCH) begin
      s.last_disc   = '0;
      s.rom         = '0;
      s.tally       = '0;
      s.finished    = 1'b0;
      s.pass_active = 1'b0;
      s.bit_pos     = 7'd1;
      r.status      = ST_ACK;
    end else if (op == OP_START_PASS) begin
      if (!s.finished) begin
        s.bit_pos     = 7'd1;
        s.zero_pos    = '0;
        s.crc         = '0;
        s.pass_active = 1'b1;
        r.status      = ST_ACK;
      end
    end else if (op == OP_BIT_PAIR && s.pass_active) begin
      if (idb && cmp) begin
        close_pass(s, limit);
        r.status = ST_ABORT;
      end else begin
        idx = s.bit_pos[5:0] - 6'd1;
        if (idb != cmp) begin
          d = idb;
        end else begin
          if (s.bit_pos == s.last_disc) begin
            d = 1'b1;
          end else if (s.bit_pos > s.last_disc) begin
            d = 1'b0;
          end else begin
            d = s.rom[idx];
          end
          if (!d) begin
            s.zero_pos = s.bit_pos;
          end
        end
        s.rom[idx]   = d;
        s.crc        = crc8_shift(s.crc, d);
        r.direction  = d;
        r.write_back = 1'b1;
        r.status     = ST_BIT;
        if (int'(s.bit_pos) >= ROM_BITS) begin
          if (s.crc == '0) begin
            if (s.tally < limit) begin
              s.tally = s.tally + 8'd1;
            end
            r.status = ST_VALID;
          end else begin
            r.status = ST_CRCERR;
          end
          s.bit_pos = 7'(ROM_BITS + 1);
          close_pass(s, limit);
        end else begin
          s.bit_pos = s.bit_pos + 7'd1;
        end
      end
    end
    r.rom_code        = s.rom;
    r.found_count     = s.tally;
    r.search_finished = s.finished;
  endtask

  task automatic flag_mismatch(input string field, input logic [63:0] got,
                               input logic [63:0] want);
    if (err_cnt < 50) begin
      $display("mismatch on %s at result %0d: got %0h, expected %0h",
               field, done_cnt, got, want);
    end
    err_cnt++;
  endtask

  task automatic send_word(input logic [1:0] op, input logic idb, input logic cmp,
                           output srch_result_t r);
    bus_word_t w;
    w.op  = op;
    w.idb = idb;
    w.cmp = cmp;
    search_decide(plan_state, max_dev, op, idb, cmp, r);
    outgoing_words.push_back(w);
    sent_cnt++;
    if (r.status != ST_IGNORED) begin
      work_cnt++;
    end
  endtask

  function automatic logic [63:0] make_rom(input bit good);
    logic [63:0] code;
    logic [7:0]  crc;
    int          k;
    int          flip;
    code = {$urandom, $urandom};
    crc = 8'd0;
    for (k = 0; k < 56; k++) begin
      crc = crc8_shift(crc, code[k]);
    end
    code[63:56] = crc;
    if (!good) begin
      flip = int'($urandom_range(63));
      code[flip] = ~code[flip];
    end
    return code;
  endfunction

  task automatic run_pass();
    srch_result_t r;
    logic [7:0]   alive;
    logic         idb;
    logic         cmp;
    int           k;
    int           j;
    int           quit_at;
    send_word(OP_START_PASS, 1'b0, 1'b0, r);
    if (r.status == ST_IGNORED) begin
      return;
    end
    alive = '0;
    for (j = 0; j < bus_roms.size(); j++) begin
      alive[j] = 1'b1;
    end
    quit_at = ($urandom_range(49) == 0) ? int'($urandom_range(63)) : 64;
    for (k = 0; k < quit_at; k++) begin
      idb = 1'b1;
      cmp = 1'b1;
      for (j = 0; j < bus_roms.size(); j++) begin
        if (alive[j]) begin
          idb = idb & bus_roms[j][k];
          cmp = cmp & ~bus_roms[j][k];
        end
      end
      if ($urandom_range(299) == 0) begin
        idb = ~idb;
      end
      send_word(OP_BIT_PAIR, idb, cmp, r);
      if (r.status == ST_ABORT) begin
        return;
      end
      for (j = 0; j < bus_roms.size(); j++) begin
        if (bus_roms[j][k] != r.direction) begin
          alive[j] = 1'b0;
        end
      end
    end
  endtask

  // A negative device count keeps the devices and the search already under way.
  task automatic run_search(input int ndev, input int max_passes, input int bad_pct);
    srch_result_t r;
    int           j;
    int           p;
    if (ndev >= 0) begin
      send_word(OP_NEW_SEARCH, 1'b0, 1'b0, r);
      bus_roms.delete();
      for (j = 0; j < ndev; j++) begin
        bus_roms.push_back(make_rom($urandom_range(99) >= bad_pct));
      end
    end
    for (p = 0; p < max_passes && !plan_state.finished; p++) begin
      run_pass();
    end
  endtask

  task automatic settle();
    while (done_cnt < sent_cnt) @(negedge clk);
  endtask

  task automatic set_limit(input logic [7:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    max_dev = v;
  endtask

  always @(posedge clk) begin : drive_in
    srch_result_t want;
    bus_word_t    w;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        search_decide(track_state, max_dev, in_tuser, in_tdata[0], in_tdata[1], want);
        pending_results.push_back(want);
      end
      if (in_tvalid && !in_tready) begin
        in_tvalid <= 1'b1;
      end else if (outgoing_words.size() != 0 && $urandom_range(99) >= send_idle) begin
        w = outgoing_words.pop_front();
        in_tvalid <= 1'b1;
        in_tuser  <= w.op;
        in_tdata  <= {6'd0, w.cmp, w.idb};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : watch_out
    srch_result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall);
      if (out_tvalid && out_tready) begin
        if (pending_results.size() == 0) begin
          flag_mismatch("word with nothing pending", out_tdata[65:2], 64'd0);
        end else begin
          want = pending_results.pop_front();
          done_cnt++;
          if (out_tdata[0] !== want.direction)
            flag_mismatch("direction", 64'(out_tdata[0]), 64'(want.direction));
          if (out_tdata[1] !== want.write_back)
            flag_mismatch("write_back", 64'(out_tdata[1]), 64'(want.write_back));
          if (out_tuser !== want.status)
            flag_mismatch("status", 64'(out_tuser), 64'(want.status));
          if (out_tdata[65:2] !== want.rom_code)
            flag_mismatch("rom_code", out_tdata[65:2], want.rom_code);
          if (out_tdata[73:66] !== want.found_count)
            flag_mismatch("found_count", 64'(out_tdata[73:66]), 64'(want.found_count));
          if (out_tdata[74] !== want.search_finished)
            flag_mismatch("search_finished", 64'(out_tdata[74]), 64'(want.search_finished));
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    srch_result_t r;
    int           ph;
    int           goal;
    int           n;
    plan_state = '0;
    plan_state.bit_pos = 7'd1;
    track_state = plan_state;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    set_limit(DEV_LIMIT_RESET);

    send_word(OP_BIT_PAIR, 1'b0, 1'b0, r);
    send_word(OP_UNDEF, 1'b1, 1'b1, r);
    send_word(OP_START_PASS, 1'b0, 1'b0, r);
    send_word(OP_BIT_PAIR, 1'b1, 1'b1, r);
    send_word(OP_START_PASS, 1'b1, 1'b0, r);
    send_word(OP_NEW_SEARCH, 1'b0, 1'b1, r);
    send_word(OP_START_PASS, 1'b0, 1'b0, r);
    send_word(OP_BIT_PAIR, 1'b1, 1'b0, r);
    send_word(OP_BIT_PAIR, 1'b0, 1'b1, r);
    send_word(OP_BIT_PAIR, 1'b0, 1'b0, r);
    send_word(OP_BIT_PAIR, 1'b0, 1'b0, r);
    send_word(OP_START_PASS, 1'b0, 1'b0, r);
    send_word(OP_BIT_PAIR, 1'b0, 1'b0, r);
    send_word(OP_BIT_PAIR, 1'b1, 1'b1, r);
    send_word(OP_START_PASS, 1'b0, 1'b0, r);
    send_word(OP_BIT_PAIR, 1'b0, 1'b0, r);
    send_word(OP_BIT_PAIR, 1'b0, 1'b0, r);
    send_word(OP_BIT_PAIR, 1'b1, 1'b1, r);
    send_word(OP_START_PASS, 1'b0, 1'b0, r);
    send_word(OP_BIT_PAIR, 1'b0, 1'b0, r);
    send_word(OP_BIT_PAIR, 1'b0, 1'b0, r);
    send_word(OP_BIT_PAIR, 1'b1, 1'b1, r);
    send_word(OP_NEW_SEARCH, 1'b1, 1'b1, r);
    send_word(OP_UNDEF, 1'b0, 1'b0, r);
    settle();

    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin set_limit(8'd255); send_idle = 0;  recv_stall = 0;  end
        1: begin set_limit(8'd1);   send_idle = 57; recv_stall = 0;  end
        2: begin set_limit(8'd2);   send_idle = 0;  recv_stall = 57; end
        3: begin set_limit(8'($urandom_range(255, 1))); send_idle = 36; recv_stall = 36; end
        default: begin set_limit(8'd4); send_idle = 0; recv_stall = 0; end
      endcase
      goal = work_cnt + PHASE_WORK;
      if (ph > 0) begin
        run_search(-1, 8, 0);
      end
      while (work_cnt < goal) begin
        if ($urandom_range(99) < 80) begin
          run_search(($urandom_range(19) == 0) ? 0 : int'($urandom_range(4, 1)), 8, 15);
        end else begin
          n = int'($urandom_range(6, 1));
          repeat (n) begin
            send_word(2'($urandom_range(3)), 1'($urandom_range(1)), 1'($urandom_range(1)), r);
          end
        end
      end
      // Leave a search open so that the next limit applies to a count already made.
      if (ph < PHASES - 1) begin
        run_search(3, 1, 0);
      end
      settle();
    end

    repeat (12) @(posedge clk);
    if (pending_results.size() != 0) begin
      flag_mismatch("words never delivered", 64'(pending_results.size()), 64'd0);
    end
    if (err_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
